// ===== hw/rtl/ipv4p_pkg.sv =====
// Package for the dotted-decimal IPv4 text parser.
// Holds the beat structs, parser state types, status codes and character helpers.
// No dependencies.
package ipv4p_pkg;

    // Default limit for the position counter.
    localparam int MAX_FIELD_LEN_DEF = 255;

    // Largest value shown on the consumed field.
    localparam int CONSUMED_MAX = 255;

    // Character codes.
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Octet and dot limits.
    localparam logic [11:0] OCTET_MAX  = 12'd255;
    localparam logic [1:0]  DOTS_FULL  = 2'd3;

    // Status codes.
    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_MISSING      = 4'd1;
    localparam logic [3:0] ST_NO_DIGIT     = 4'd2;
    localparam logic [3:0] ST_DOT_NO_DIGIT = 4'd3;
    localparam logic [3:0] ST_MANY_DOTS    = 4'd4;
    localparam logic [3:0] ST_OCTET_BIG    = 4'd5;
    localparam logic [3:0] ST_STRANGE      = 4'd6;
    localparam logic [3:0] ST_FEW_DOTS     = 4'd7;
    localparam logic [3:0] ST_TRAIL_DOT    = 4'd8;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_SKIP,
        PH_PARSE,
        PH_DROP
    } phase_t;

    // One input beat.
    typedef struct packed {
        logic [7:0] ch;
        logic       last_char;
    } char_beat_t;

    // One result beat.
    typedef struct packed {
        logic [31:0] address;
        logic [3:0]  status;
        logic [7:0]  consumed;
    } result_beat_t;

    // Parser state apart from the position counter.
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  octet_acc;
        logic [23:0] prior_octets;
        logic [1:0]  dot_count;
        logic        saw_digit;
    } parse_state_t;

    // Whitespace: space, tab, LF, VT, FF, CR.
    function automatic logic is_ws(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, [CH_LF:CH_CR]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

endpackage

// ===== hw/rtl/ipv4p_step.sv =====
// Combinational update of the parser for one character.
// Computes the next parser state and the result beat, if any.
// Depends on ipv4p_pkg.
module ipv4p_step
    import ipv4p_pkg::*;
#(
    parameter int MAX_FIELD_LEN = MAX_FIELD_LEN_DEF,
    parameter int PW            = $clog2(MAX_FIELD_LEN + 1)
)
(
    input  parse_state_t cur,
    input  logic [PW-1:0] position,
    input  char_beat_t    beat,
    output parse_state_t  nxt,
    output logic [PW-1:0] position_nxt,
    output logic          emit,
    output result_beat_t  result
);

    logic [7:0]    c;
    logic          last;
    logic          c_ws;
    logic          c_digit;
    logic          c_dot;
    logic          c_term;
    logic          parsing;
    logic [PW-1:0] pos_adv;
    logic [11:0]   octet_val;

    // Candidate state after a dot or digit has been taken.
    logic [7:0]    cand_acc;
    logic [23:0]   cand_prior;
    logic [1:0]    cand_dots;
    logic          cand_saw;
    logic [PW-1:0] emit_pos;

    assign c       = beat.ch;
    assign last    = beat.last_char;
    assign c_ws    = is_ws(c);
    assign c_digit = is_digit(c);
    assign c_dot   = (c == CH_DOT);
    assign c_term  = c_ws || (c == CH_COMMA);

    // A digit in the skip phase starts the address on this same character.
    assign parsing = (cur.phase == PH_PARSE) || ((cur.phase == PH_SKIP) && c_digit);

    assign pos_adv = (position < PW'(MAX_FIELD_LEN)) ? position + PW'(1) : position;

    // Octet times ten plus the new digit.
    assign octet_val = {1'b0, cur.octet_acc, 3'b000} + {3'b000, cur.octet_acc, 1'b0}
                     + {8'h00, 4'(c - CH_ZERO)};

    // Dot shifts the current octet into the completed ones; digit grows the octet.
    always_comb
    begin
        cand_acc   = cur.octet_acc;
        cand_prior = cur.prior_octets;
        cand_dots  = cur.dot_count;
        cand_saw   = cur.saw_digit;
        if (c_dot)
        begin
            cand_acc   = 8'h00;
            cand_prior = {cur.prior_octets[15:0], cur.octet_acc};
            cand_dots  = cur.dot_count + 2'd1;
            cand_saw   = 1'b0;
        end
        else if (c_digit)
        begin
            cand_acc = octet_val[7:0];
            cand_saw = 1'b1;
        end
    end

    // Result decision: whether a beat goes out, with which status and address.
    always_comb
    begin
        emit           = 1'b0;
        result.address = 32'h0;
        result.status  = ST_OK;
        emit_pos       = position;

        if (cur.phase == PH_SKIP && c_ws)
        begin
            emit          = last;
            result.status = ST_MISSING;
            emit_pos      = pos_adv;
        end
        else if (cur.phase == PH_SKIP && !c_digit)
        begin
            emit          = 1'b1;
            result.status = ST_NO_DIGIT;
        end
        else if (parsing)
        begin
            if (c_dot && !cur.saw_digit)
            begin
                emit          = 1'b1;
                result.status = ST_DOT_NO_DIGIT;
            end
            else if (c_dot && cur.dot_count >= DOTS_FULL)
            begin
                emit          = 1'b1;
                result.status = ST_MANY_DOTS;
            end
            else if (c_digit && octet_val > OCTET_MAX)
            begin
                emit          = 1'b1;
                result.status = ST_OCTET_BIG;
            end
            else if (c_dot || c_digit || c_term)
            begin
                // Finish on a terminator, or on the last character once taken.
                emit     = c_term || last;
                emit_pos = c_term ? position : pos_adv;
                if (cand_dots != DOTS_FULL)
                begin
                    result.status = ST_FEW_DOTS;
                end
                else if (!cand_saw)
                begin
                    result.status = ST_TRAIL_DOT;
                end
                else
                begin
                    result.address = {cand_prior, cand_acc};
                end
            end
            else
            begin
                emit          = 1'b1;
                result.status = ST_STRANGE;
            end
        end

        result.consumed = (32'(emit_pos) > 32'(CONSUMED_MAX)) ? 8'hFF : 8'(emit_pos);
    end

    // Next state.
    always_comb
    begin
        nxt          = cur;
        position_nxt = position;
        if (cur.phase == PH_DROP || emit)
        begin
            if (last)
            begin
                nxt.phase        = PH_SKIP;
                nxt.octet_acc    = 8'h00;
                nxt.prior_octets = 24'h0;
                nxt.dot_count    = 2'd0;
                nxt.saw_digit    = 1'b0;
                position_nxt     = '0;
            end
            else
            begin
                nxt.phase = PH_DROP;
            end
        end
        else if (cur.phase == PH_SKIP && c_ws)
        begin
            position_nxt = pos_adv;
        end
        else
        begin
            nxt.phase        = PH_PARSE;
            nxt.octet_acc    = cand_acc;
            nxt.prior_octets = cand_prior;
            nxt.dot_count    = cand_dots;
            nxt.saw_digit    = cand_saw;
            position_nxt     = pos_adv;
        end
    end

endmodule

// ===== hw/rtl/ipv4_dotted_text_parser.sv =====
// Dotted-decimal IPv4 text parser, one character per beat.
// An accepted character is held in the input register; its result beat is registered.
// Throughput: one character per cycle unless a pending result is stalled.
// Reset puts the parser in the leading-whitespace phase with all counters zero;
// there is no clearing pass, so characters are taken from the first cycle.
// Depends on ipv4p_pkg and ipv4p_step.
module ipv4_dotted_text_parser
    import ipv4p_pkg::*;
#(
    parameter int MAX_FIELD_LEN = MAX_FIELD_LEN_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    output logic         char_stall,
    input  char_beat_t   char_beat,
    output logic         result_valid,
    input  logic         result_stall,
    output result_beat_t result_beat
);

    localparam int PW = $clog2(MAX_FIELD_LEN + 1);

    logic          in_vld_reg;
    char_beat_t    in_beat_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    logic [PW-1:0] position_reg;
    logic [PW-1:0] position_next;
    logic          out_vld_reg;
    result_beat_t  out_beat_reg;
    result_beat_t  step_result;
    logic          step_emit;
    logic          out_free;
    logic          fire;

    ipv4p_step #(
        .MAX_FIELD_LEN (MAX_FIELD_LEN),
        .PW            (PW)
    ) u_step (
        .cur          (state_reg),
        .position     (position_reg),
        .beat         (in_beat_reg),
        .nxt          (state_next),
        .position_nxt (position_next),
        .emit         (step_emit),
        .result       (step_result)
    );

    // The held character is processed when its result, if any, has room.
    assign out_free   = !out_vld_reg || !result_stall;
    assign fire       = in_vld_reg && (!step_emit || out_free);
    assign char_stall = in_vld_reg && !fire;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            in_vld_reg <= char_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (!char_stall && char_valid)
        begin
            in_beat_reg <= char_beat;
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_SKIP;
            state_reg.octet_acc    <= 8'h00;
            state_reg.prior_octets <= 24'h0;
            state_reg.dot_count    <= 2'd0;
            state_reg.saw_digit    <= 1'b0;
            position_reg           <= '0;
        end
        else if (fire)
        begin
            state_reg    <= state_next;
            position_reg <= position_next;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fire && step_emit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (fire && step_emit)
        begin
            out_beat_reg <= step_result;
        end
    end

    assign result_valid = out_vld_reg;
    assign result_beat  = out_beat_reg;

endmodule
